@@ rtl/lao_pkg.sv @@
// Shared types and constants for the Lorenz attractor oscillator.
`default_nettype none

package lao_pkg;

    localparam int DEF_STATE_WIDTH = 32;
    localparam int DIG_W           = 16;
    localparam int CV_W            = 16;
    localparam int OUT_W           = 16;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int KNOB_W          = 23;
    localparam int G_W             = 29;

    localparam logic [2:0] REG_SIGMA = 3'd0;
    localparam logic [2:0] REG_BETA  = 3'd1;
    localparam logic [2:0] REG_RHO   = 3'd2;
    localparam logic [2:0] REG_PITCH = 3'd3;
    localparam logic [2:0] REG_TSTEP = 3'd4;

    localparam logic [20:0] SIGMA_KNOB_RST = 21'd655360;
    localparam logic [17:0] BETA_KNOB_RST  = 18'd174763;
    localparam logic [22:0] RHO_KNOB_RST   = 23'd1835008;
    localparam logic [16:0] PITCH_KNOB_RST = 17'd32768;
    localparam logic [19:0] TSTEP_RST      = 20'd89478;

    localparam logic [KNOB_W-1:0] SIGMA_MIN = 23'd196608;
    localparam logic [KNOB_W-1:0] SIGMA_MAX = 23'd1966080;
    localparam logic [KNOB_W-1:0] BETA_MIN  = 23'd32768;
    localparam logic [KNOB_W-1:0] BETA_MAX  = 23'd196608;
    localparam logic [KNOB_W-1:0] RHO_MIN   = 23'd851968;
    localparam logic [KNOB_W-1:0] RHO_MAX   = 23'd5242880;
    localparam logic [KNOB_W-1:0] PITCH_MIN = 23'd66;
    localparam logic [KNOB_W-1:0] PITCH_MAX = 23'd65536;

    // ceil(2^23/5): exact quotient by five for magnitudes up to 2^21
    localparam logic [20:0] RECIP5     = 21'd1677722;
    localparam logic [8:0]  GAIN_375   = 9'd375;
    localparam logic [13:0] OUT_GAIN_X = 14'd14418;
    localparam logic [13:0] OUT_GAIN_Y = 14'd10748;

    typedef enum logic [3:0] {
        OP_CV_SIGMA,
        OP_CV_BETA,
        OP_CV_RHO,
        OP_CV_PITCH,
        OP_PITCH375,
        OP_GAIN,
        OP_DX,
        OP_P1,
        OP_P2,
        OP_P3,
        OP_STEP_X,
        OP_STEP_Y,
        OP_STEP_Z,
        OP_OUT_X,
        OP_OUT_Y
    } op_t;

    typedef enum logic [2:0] {
        SH_0,
        SH_16,
        SH_23,
        SH_32,
        SH_F,
        SH_F6
    } shift_t;

    typedef struct packed {
        logic load;
        logic start;
        logic write;
        logic publish;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [20:0] sigma;
        logic [17:0] beta;
        logic [22:0] rho;
        logic [16:0] pitch;
        logic [19:0] time_step;
    } knobs_t;

endpackage

`default_nettype wire

@@ rtl/lao_mul.sv @@
// Shared sign-magnitude multiplier, 16-bit digit per cycle, with selectable right shift.
`default_nettype none

module lao_mul #(
    parameter int A_W  = 43,
    parameter int B_W  = 32,
    parameter int FRAC = 21
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire  signed [A_W-1:0]    a,
    input  wire  signed [B_W-1:0]    b,
    input  wire  lao_pkg::shift_t    sh,
    output logic signed [A_W-1:0]    result,
    output logic                     done
);

    localparam int DIG   = lao_pkg::DIG_W;
    localparam int ND    = (B_W + DIG - 1) / DIG;
    localparam int MB_W  = ND * DIG;
    localparam int P_W   = A_W + MB_W;
    localparam int CNT_W = $clog2(ND + 1);

    logic [A_W-1:0]        mag_a_reg;
    logic [MB_W-1:0]       mag_b_reg;
    logic [P_W-1:0]        acc_reg;
    logic                  neg_reg;
    lao_pkg::shift_t       sh_reg;
    logic signed [A_W-1:0] res_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  fin_reg;
    logic                  done_reg;

    logic [A_W-1:0]        mag_a_c;
    logic [B_W-1:0]        mag_b_c;
    logic [A_W+DIG-1:0]    pp;
    logic [P_W-1:0]        acc_next;
    logic [P_W-1:0]        shv;
    logic [A_W-1:0]        mag_c;
    logic signed [A_W-1:0] res_c;

    assign mag_a_c  = a[A_W-1] ? A_W'(-a) : A_W'(a);
    assign mag_b_c  = b[B_W-1] ? B_W'(-b) : B_W'(b);
    assign pp       = mag_a_reg * mag_b_reg[MB_W-1 -: DIG];
    assign acc_next = P_W'(acc_reg << DIG) + P_W'(pp);

    always_comb
    begin
        case (sh_reg)
            lao_pkg::SH_0:  shv = acc_reg;
            lao_pkg::SH_16: shv = acc_reg >> 16;
            lao_pkg::SH_23: shv = acc_reg >> 23;
            lao_pkg::SH_32: shv = acc_reg >> 32;
            lao_pkg::SH_F:  shv = acc_reg >> FRAC;
            lao_pkg::SH_F6: shv = acc_reg >> (FRAC + 6);
            default:        shv = acc_reg;
        endcase
        mag_c = shv[A_W-1:0];
        res_c = neg_reg ? A_W'(-mag_c) : mag_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(ND);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_a_reg <= mag_a_c;
            mag_b_reg <= MB_W'(mag_b_c);
            acc_reg   <= '0;
            neg_reg   <= a[A_W-1] ^ b[B_W-1];
            sh_reg    <= sh;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg   <= acc_next;
            mag_b_reg <= mag_b_reg << DIG;
        end
        if (fin_reg)
        begin
            res_reg <= res_c;
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

@@ rtl/lao_datapath.sv @@
// Datapath: parameter, derivative and state registers, operand selection, output word register.
`default_nettype none

module lao_datapath #(
    parameter int STATE_WIDTH = lao_pkg::DEF_STATE_WIDTH
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire  lao_pkg::cmd_t    cmd,
    output lao_pkg::sts_t          sts,
    input  wire  lao_pkg::knobs_t  knobs,
    input  wire  [63:0]            in_data,
    input  wire                    out_ready,
    output logic                   out_valid,
    output logic [31:0]            out_data
);

    localparam int W      = STATE_WIDTH;
    localparam int F      = W - 11;
    localparam int A_W    = W + 11;
    localparam int B_W    = (W > 30) ? W : 30;
    localparam int RHO_UP = (F >= 16) ? F - 16 : 0;
    localparam int RHO_DN = (F >= 16) ? 0 : 16 - F;
    localparam int KW     = lao_pkg::KNOB_W;

    localparam logic signed [W-1:0] ONE = {10'd0, 1'b1, {F{1'b0}}};

    logic signed [15:0]      cv_sigma_reg, cv_beta_reg, cv_rho_reg, cv_pitch_reg;
    logic [20:0]             sigma_reg;
    logic [17:0]             beta_reg;
    logic [22:0]             rho_reg;
    logic [16:0]             pitch_reg;
    logic [lao_pkg::G_W-1:0] g_reg;
    logic signed [A_W-1:0]   dx_reg, dy_reg, dz_reg;
    logic signed [W-1:0]     x_reg, y_reg, z_reg;
    logic signed [15:0]      ox_reg, oy_reg;
    logic                    out_valid_reg;
    logic [31:0]             out_data_reg;

    logic signed [A_W-1:0]   op_a;
    logic signed [B_W-1:0]   op_b;
    lao_pkg::shift_t         op_sh;
    logic signed [A_W-1:0]   mul_res;
    logic                    mul_done;
    logic signed [A_W-1:0]   rho_s;

    logic [KW-1:0]           knob_sel, lo_sel, hi_sel;
    logic signed [25:0]      psum, lo_s, hi_s;
    logic [KW-1:0]           param_c;
    logic signed [W-1:0]     step_old;
    logic signed [A_W:0]     step_sum;
    logic signed [W-1:0]     step_c;
    logic signed [15:0]      out_c;

    function automatic logic signed [W-1:0] sat_state(input logic signed [A_W:0] v);
        if ((&v[A_W:W-1]) || !(|v[A_W:W-1]))
            return v[W-1:0];
        else if (v[A_W])
            return {1'b1, {(W-1){1'b0}}};
        else
            return {1'b0, {(W-1){1'b1}}};
    endfunction

    function automatic logic signed [15:0] sat_out(input logic signed [A_W-1:0] v);
        if ((&v[A_W-1:15]) || !(|v[A_W-1:15]))
            return v[15:0];
        else if (v[A_W-1])
            return 16'sh8000;
        else
            return 16'sh7fff;
    endfunction

    assign rho_s = (A_W'(rho_reg) << RHO_UP) >> RHO_DN;

    always_comb
    begin
        op_a  = '0;
        op_b  = '0;
        op_sh = lao_pkg::SH_0;
        case (cmd.op)
            lao_pkg::OP_CV_SIGMA:
            begin
                op_a  = A_W'(cv_sigma_reg) <<< 5;
                op_b  = B_W'(lao_pkg::RECIP5);
                op_sh = lao_pkg::SH_23;
            end
            lao_pkg::OP_CV_BETA:
            begin
                op_a  = A_W'(cv_beta_reg) <<< 5;
                op_b  = B_W'(lao_pkg::RECIP5);
                op_sh = lao_pkg::SH_23;
            end
            lao_pkg::OP_CV_RHO:
            begin
                op_a  = A_W'(cv_rho_reg) <<< 5;
                op_b  = B_W'(lao_pkg::RECIP5);
                op_sh = lao_pkg::SH_23;
            end
            lao_pkg::OP_CV_PITCH:
            begin
                op_a  = A_W'(cv_pitch_reg) <<< 5;
                op_b  = B_W'(lao_pkg::RECIP5);
                op_sh = lao_pkg::SH_23;
            end
            lao_pkg::OP_PITCH375:
            begin
                op_a  = A_W'(pitch_reg);
                op_b  = B_W'(lao_pkg::GAIN_375);
                op_sh = lao_pkg::SH_0;
            end
            lao_pkg::OP_GAIN:
            begin
                op_a  = A_W'(knobs.time_step);
                op_b  = B_W'(g_reg);
                op_sh = lao_pkg::SH_16;
            end
            lao_pkg::OP_DX:
            begin
                op_a  = A_W'(y_reg) - A_W'(x_reg);
                op_b  = B_W'(sigma_reg);
                op_sh = lao_pkg::SH_16;
            end
            lao_pkg::OP_P1:
            begin
                op_a  = rho_s - A_W'(z_reg);
                op_b  = B_W'(x_reg);
                op_sh = lao_pkg::SH_F;
            end
            lao_pkg::OP_P2:
            begin
                op_a  = A_W'(x_reg);
                op_b  = B_W'(y_reg);
                op_sh = lao_pkg::SH_F;
            end
            lao_pkg::OP_P3:
            begin
                op_a  = A_W'(z_reg);
                op_b  = B_W'(beta_reg);
                op_sh = lao_pkg::SH_16;
            end
            lao_pkg::OP_STEP_X:
            begin
                op_a  = dx_reg;
                op_b  = B_W'(g_reg);
                op_sh = lao_pkg::SH_32;
            end
            lao_pkg::OP_STEP_Y:
            begin
                op_a  = dy_reg;
                op_b  = B_W'(g_reg);
                op_sh = lao_pkg::SH_32;
            end
            lao_pkg::OP_STEP_Z:
            begin
                op_a  = dz_reg;
                op_b  = B_W'(g_reg);
                op_sh = lao_pkg::SH_32;
            end
            lao_pkg::OP_OUT_X:
            begin
                op_a  = A_W'(x_reg);
                op_b  = B_W'(lao_pkg::OUT_GAIN_X);
                op_sh = lao_pkg::SH_F6;
            end
            lao_pkg::OP_OUT_Y:
            begin
                op_a  = A_W'(y_reg);
                op_b  = B_W'(lao_pkg::OUT_GAIN_Y);
                op_sh = lao_pkg::SH_F6;
            end
            default:
            begin
                op_a  = '0;
                op_b  = '0;
                op_sh = lao_pkg::SH_0;
            end
        endcase
    end

    lao_mul #(
        .A_W  (A_W),
        .B_W  (B_W),
        .FRAC (F)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .a      (op_a),
        .b      (op_b),
        .sh     (op_sh),
        .result (mul_res),
        .done   (mul_done)
    );

    // knob plus cv term, clamped
    always_comb
    begin
        case (cmd.op)
            lao_pkg::OP_CV_BETA:
            begin
                knob_sel = KW'(knobs.beta);
                lo_sel   = lao_pkg::BETA_MIN;
                hi_sel   = lao_pkg::BETA_MAX;
            end
            lao_pkg::OP_CV_RHO:
            begin
                knob_sel = KW'(knobs.rho);
                lo_sel   = lao_pkg::RHO_MIN;
                hi_sel   = lao_pkg::RHO_MAX;
            end
            lao_pkg::OP_CV_PITCH:
            begin
                knob_sel = KW'(knobs.pitch);
                lo_sel   = lao_pkg::PITCH_MIN;
                hi_sel   = lao_pkg::PITCH_MAX;
            end
            default:
            begin
                knob_sel = KW'(knobs.sigma);
                lo_sel   = lao_pkg::SIGMA_MIN;
                hi_sel   = lao_pkg::SIGMA_MAX;
            end
        endcase
        psum = $signed({3'b000, knob_sel}) + 26'(mul_res);
        lo_s = $signed({3'b000, lo_sel});
        hi_s = $signed({3'b000, hi_sel});
        if (psum < lo_s)
            param_c = lo_sel;
        else if (psum > hi_s)
            param_c = hi_sel;
        else
            param_c = psum[KW-1:0];
    end

    always_comb
    begin
        case (cmd.op)
            lao_pkg::OP_STEP_Y: step_old = y_reg;
            lao_pkg::OP_STEP_Z: step_old = z_reg;
            default:            step_old = x_reg;
        endcase
        step_sum = (A_W+1)'(step_old) + (A_W+1)'(mul_res);
        step_c   = sat_state(step_sum);
        out_c    = sat_out(mul_res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= ONE;
            y_reg         <= ONE;
            z_reg         <= ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                case (cmd.op)
                    lao_pkg::OP_STEP_X: x_reg <= step_c;
                    lao_pkg::OP_STEP_Y: y_reg <= step_c;
                    lao_pkg::OP_STEP_Z: z_reg <= step_c;
                    default:            x_reg <= x_reg;
                endcase
            end
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cv_sigma_reg <= in_data[15:0];
            cv_beta_reg  <= in_data[31:16];
            cv_rho_reg   <= in_data[47:32];
            cv_pitch_reg <= in_data[63:48];
        end
        if (cmd.write)
        begin
            case (cmd.op)
                lao_pkg::OP_CV_SIGMA: sigma_reg <= param_c[20:0];
                lao_pkg::OP_CV_BETA:  beta_reg  <= param_c[17:0];
                lao_pkg::OP_CV_RHO:   rho_reg   <= param_c[22:0];
                lao_pkg::OP_CV_PITCH: pitch_reg <= param_c[16:0];
                lao_pkg::OP_PITCH375: g_reg     <= mul_res[lao_pkg::G_W-1:0];
                lao_pkg::OP_GAIN:     g_reg     <= mul_res[lao_pkg::G_W-1:0];
                lao_pkg::OP_DX:       dx_reg    <= mul_res;
                lao_pkg::OP_P1:       dy_reg    <= mul_res - A_W'(y_reg);
                lao_pkg::OP_P2:       dz_reg    <= mul_res;
                lao_pkg::OP_P3:       dz_reg    <= dz_reg - mul_res;
                lao_pkg::OP_OUT_X:    ox_reg    <= out_c;
                lao_pkg::OP_OUT_Y:    oy_reg    <= out_c;
                default:              g_reg     <= g_reg;
            endcase
        end
        if (cmd.publish)
        begin
            out_data_reg <= {oy_reg, ox_reg};
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/lao_ctrl.sv @@
// Controller: sequences the fifteen multiply steps of one tick and the output hand-off.
`default_nettype none

module lao_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  lao_pkg::sts_t  sts,
    output lao_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_PUBLISH
    } state_t;

    state_t         state_reg, state_next;
    lao_pkg::op_t   op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = lao_pkg::OP_CV_SIGMA;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.mul_done)
                begin
                    cmd.write = 1'b1;
                    if (op_reg == lao_pkg::OP_OUT_Y)
                    begin
                        state_next = ST_PUBLISH;
                    end
                    else
                    begin
                        op_next    = lao_pkg::op_t'(4'(op_reg) + 4'd1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_PUBLISH:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= lao_pkg::OP_CV_SIGMA;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lorenz_attractor_oscillator_top.sv @@
// Lorenz oscillator top: APB knob registers, stream ports, controller and datapath.
// Each input word runs the fifteen multiply steps, then its output word is published.
// All fifteen products share one multiplier that takes one 16-bit digit per cycle.
// A new input word is accepted only after the previous output word has been published;
// the finished word waits in its own register until the output port takes it.
// Reset: x, y, z return to 1.0 and the knobs to their defaults; no clearing pass.
`default_nettype none

module lorenz_attractor_oscillator_top #(
    parameter int STATE_WIDTH = lao_pkg::DEF_STATE_WIDTH
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [lao_pkg::ADDR_W-1:0]   paddr,
    input  wire  [lao_pkg::DATA_W-1:0]   pwdata,
    output logic [lao_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [63:0]                  s_tdata,   // sigma_cv, beta_cv, rho_cv, pitch_cv
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [31:0]                  m_tdata    // x_out, y_out
);

    logic [20:0]     sigma_knob_reg;
    logic [17:0]     beta_knob_reg;
    logic [22:0]     rho_knob_reg;
    logic [16:0]     pitch_knob_reg;
    logic [19:0]     time_step_reg;

    logic            cfg_wr;
    logic [2:0]      reg_idx;
    lao_pkg::knobs_t knobs;
    lao_pkg::cmd_t   cmd;
    lao_pkg::sts_t   sts;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_knob_reg <= lao_pkg::SIGMA_KNOB_RST;
            beta_knob_reg  <= lao_pkg::BETA_KNOB_RST;
            rho_knob_reg   <= lao_pkg::RHO_KNOB_RST;
            pitch_knob_reg <= lao_pkg::PITCH_KNOB_RST;
            time_step_reg  <= lao_pkg::TSTEP_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                lao_pkg::REG_SIGMA: sigma_knob_reg <= pwdata[20:0];
                lao_pkg::REG_BETA:  beta_knob_reg  <= pwdata[17:0];
                lao_pkg::REG_RHO:   rho_knob_reg   <= pwdata[22:0];
                lao_pkg::REG_PITCH: pitch_knob_reg <= pwdata[16:0];
                lao_pkg::REG_TSTEP: time_step_reg  <= pwdata[19:0];
                default:            time_step_reg  <= time_step_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lao_pkg::REG_SIGMA: prdata = 32'(sigma_knob_reg);
            lao_pkg::REG_BETA:  prdata = 32'(beta_knob_reg);
            lao_pkg::REG_RHO:   prdata = 32'(rho_knob_reg);
            lao_pkg::REG_PITCH: prdata = 32'(pitch_knob_reg);
            lao_pkg::REG_TSTEP: prdata = 32'(time_step_reg);
            default:            prdata = '0;
        endcase
    end

    assign knobs.sigma     = sigma_knob_reg;
    assign knobs.beta      = beta_knob_reg;
    assign knobs.rho       = rho_knob_reg;
    assign knobs.pitch     = pitch_knob_reg;
    assign knobs.time_step = time_step_reg;

    lao_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lao_datapath #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .knobs     (knobs),
        .in_data   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire
